@@ rtl/rip_pkg.sv @@
// Shared types and constants for the radix integer text parser.
// Holds the parse state record and its reset value; no dependencies.
package rip_pkg;

  localparam int VALUE_BITS = 64;

  typedef enum logic [3:0] {
    PH_FIRST  = 4'd0,
    PH_PRE0   = 4'd1,
    PH_PRE1   = 4'd2,
    PH_WS     = 4'd3,
    PH_SIGNED = 4'd4,
    PH_ZERO   = 4'd5,
    PH_DIGITS = 4'd6,
    PH_DONE   = 4'd7
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [63:0] acc;
    logic        outer_minus;
    logic        inner_minus;
    logic [5:0]  base;
    logic        digit_seen;
    logic        overflow_seen;
    logic        radix_bad;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:         PH_FIRST,
    acc:           64'd0,
    outer_minus:   1'b0,
    inner_minus:   1'b0,
    base:          6'd0,
    digit_seen:    1'b0,
    overflow_seen: 1'b0,
    radix_bad:     1'b0
  };

  localparam logic [63:0] VALUE_TOP = 64'(64'd1 << (VALUE_BITS - 1));

endpackage

@@ rtl/rip_step.sv @@
// Per-byte parse step: prefix, whitespace, sign and digit handling.
// Uses rip_pkg for the state record; one multiply-accumulate by the base.
module rip_step (
  input  rip_pkg::state_t cur,
  input  logic [7:0]      text_byte,
  input  logic [5:0]      radix,
  input  logic            last_byte,
  output rip_pkg::state_t nxt
);

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] BASE_BIN  = 6'd2;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [6:0] DIGIT_NONE = 7'd99;

  function automatic logic [6:0] digit_of(input logic [7:0] b);
    logic [6:0] d;
    begin
      d = DIGIT_NONE;
      if (b >= CH_0 && b <= CH_9) d = 7'(b - CH_0);
      else if (b >= CH_LA && b <= CH_LZ) d = 7'(b - CH_LA) + 7'd10;
      else if (b >= CH_UA && b <= CH_UZ) d = 7'(b - CH_UA) + 7'd10;
      return d;
    end
  endfunction

  logic            run_pre0;
  logic            run_ws;
  logic            run_signed;
  logic            run_zero;
  logic            run_digits;
  logic [6:0]      dig;
  logic [63:0]     limit;
  logic [70:0]     prod;
  rip_pkg::state_t s;

  always_comb begin
    s          = cur;
    run_pre0   = 1'b0;
    run_ws     = 1'b0;
    run_signed = 1'b0;
    run_zero   = 1'b0;
    run_digits = 1'b0;
    dig        = digit_of(text_byte);
    limit      = 64'd0;
    prod       = 71'd0;

    case (cur.phase)
      rip_pkg::PH_FIRST: begin
        s           = rip_pkg::STATE_RESET;
        s.base      = radix;
        s.radix_bad = !(radix == 6'd0 || (radix >= RADIX_MIN && radix <= RADIX_MAX));
        if (s.radix_bad) begin
          s.phase = rip_pkg::PH_DONE;
        end else if (text_byte == CH_MINUS) begin
          s.outer_minus = 1'b1;
          s.phase       = rip_pkg::PH_PRE0;
        end else begin
          run_pre0 = 1'b1;
        end
      end
      rip_pkg::PH_PRE0: begin
        run_pre0 = 1'b1;
      end
      rip_pkg::PH_PRE1: begin
        if (text_byte == CH_LB || text_byte == CH_UB) begin
          s.base  = BASE_BIN;
          s.phase = rip_pkg::PH_WS;
        end else if (text_byte == CH_LX || text_byte == CH_UX) begin
          s.base       = BASE_HEX;
          s.digit_seen = 1'b1;
          s.acc        = 64'd0;
          s.phase      = rip_pkg::PH_DIGITS;
        end else begin
          s.digit_seen = 1'b1;
          s.acc        = 64'd0;
          if (s.base == 6'd0) s.base = BASE_OCT;
          run_digits = 1'b1;
        end
      end
      rip_pkg::PH_WS: begin
        run_ws = 1'b1;
      end
      rip_pkg::PH_SIGNED: begin
        run_signed = 1'b1;
      end
      rip_pkg::PH_ZERO: begin
        run_zero = 1'b1;
      end
      rip_pkg::PH_DIGITS: begin
        run_digits = 1'b1;
      end
      default: begin
        s.phase = rip_pkg::PH_DONE;
      end
    endcase

    if (run_pre0) begin
      if (text_byte == CH_0 && !last_byte) s.phase = rip_pkg::PH_PRE1;
      else run_ws = 1'b1;
    end

    if (run_ws) begin
      if (text_byte == CH_SPACE || (text_byte >= CH_TAB && text_byte <= CH_CR)) begin
        s.phase = rip_pkg::PH_WS;
      end else if (text_byte == CH_PLUS || text_byte == CH_MINUS) begin
        s.inner_minus = (text_byte == CH_MINUS);
        s.phase       = rip_pkg::PH_SIGNED;
      end else begin
        run_signed = 1'b1;
      end
    end

    if (run_signed) begin
      if (text_byte == CH_0 && (s.base == 6'd0 || s.base == BASE_HEX)) begin
        s.digit_seen = 1'b1;
        s.acc        = 64'd0;
        s.phase      = rip_pkg::PH_ZERO;
      end else begin
        if (s.base == 6'd0) s.base = BASE_DEC;
        run_digits = 1'b1;
      end
    end

    if (run_zero) begin
      if (text_byte == CH_LX || text_byte == CH_UX) begin
        s.base  = BASE_HEX;
        s.phase = rip_pkg::PH_DIGITS;
      end else begin
        if (s.base == 6'd0) s.base = BASE_OCT;
        run_digits = 1'b1;
      end
    end

    if (run_digits) begin
      if (dig >= {1'b0, s.base}) begin
        s.phase = rip_pkg::PH_DONE;
      end else begin
        s.phase      = rip_pkg::PH_DIGITS;
        s.digit_seen = 1'b1;
        if (!s.overflow_seen) begin
          limit = rip_pkg::VALUE_TOP - {63'd0, !s.inner_minus};
          prod  = 71'(s.acc) * 71'(s.base) + 71'(dig);
          if (prod > 71'(limit)) begin
            s.overflow_seen = 1'b1;
            s.acc           = limit;
          end else begin
            s.acc = prod[63:0];
          end
        end
      end
    end

    nxt = s;
  end

endmodule

@@ rtl/rip_result.sv @@
// Forms the signed result and flags from the final parse state.
// Uses rip_pkg for the state record and the value range.
module rip_result (
  input  rip_pkg::state_t fin,
  output logic [63:0]     parsed_value,
  output logic            number_ok,
  output logic            saturated
);

  logic        ok;
  logic        neg;
  logic        sat;
  logic [63:0] mag;

  always_comb begin
    ok  = !fin.radix_bad && fin.digit_seen;
    neg = fin.inner_minus ^ fin.outer_minus;
    mag = fin.acc;
    sat = fin.overflow_seen;
    if (fin.inner_minus && fin.outer_minus && mag == rip_pkg::VALUE_TOP) begin
      mag = rip_pkg::VALUE_TOP - 64'd1;
      sat = 1'b1;
    end
    parsed_value = ok ? (neg ? (64'd0 - mag) : mag) : 64'd0;
    number_ok    = ok;
    saturated    = ok && sat;
  end

endmodule

@@ rtl/radix_integer_text_parser.sv @@
// Top level of the radix integer text parser: stream ports and pipeline registers.
// Depends on rip_pkg, rip_step and rip_result.

// Takes one byte of a string per request and produces one signed 64-bit result per
// string, with number_ok and saturated flags. The radix is read with the first byte
// of each string (0 auto-detects, 2 to 36 is used as given). A new byte is accepted
// in every cycle unless a last byte is held; the sustained rate is one byte per clock
// while no result is held back, with one multiply-accumulate by the base per byte in
// the parse stage. After the last byte is accepted into the input register, it is
// stepped into the final-state register, then the result is formed into the output
// register, which raises the result request. Stalls on the output side hold back only
// a string's last byte, and only while a finished state waits in the final-state register.
module radix_integer_text_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
  input  logic [5:0]  s_axis_tuser,  // [5:0] radix
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [63:0] parsed_value
  output logic [1:0]  m_axis_tuser   // [0] number_ok, [1] saturated
);

  logic            in_valid;
  logic [7:0]      in_byte;
  logic [5:0]      in_radix;
  logic            in_last;
  rip_pkg::state_t st;
  rip_pkg::state_t st_next;
  logic            fin_valid;
  rip_pkg::state_t fin_st;
  logic            out_valid;
  logic [63:0]     out_value;
  logic [1:0]      out_flags;
  logic [63:0]     res_value;
  logic            res_number;
  logic            res_sat;
  logic            out_free;
  logic            fin_go;
  logic            fin_free;
  logic            step_go;

  rip_step u_step (
    .cur       (st),
    .text_byte (in_byte),
    .radix     (in_radix),
    .last_byte (in_last),
    .nxt       (st_next)
  );

  rip_result u_result (
    .fin          (fin_st),
    .parsed_value (res_value),
    .number_ok    (res_number),
    .saturated    (res_sat)
  );

  assign out_free      = !out_valid || m_axis_tready;
  assign fin_go        = fin_valid && out_free;
  assign fin_free      = !fin_valid || fin_go;
  assign step_go       = in_valid && (!in_last || fin_free);
  assign s_axis_tready = !in_valid || step_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      st        <= rip_pkg::STATE_RESET;
      fin_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (step_go) begin
        st <= in_last ? rip_pkg::STATE_RESET : st_next;
      end
      if (fin_go) begin
        fin_valid <= 1'b0;
      end
      if (step_go && in_last) begin
        fin_valid <= 1'b1;
      end
      if (out_free) begin
        out_valid <= fin_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_radix <= s_axis_tuser;
      in_last  <= s_axis_tlast;
    end
    if (step_go && in_last) begin
      fin_st <= st_next;
    end
    if (fin_go) begin
      out_value <= res_value;
      out_flags <= {res_sat, res_number};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tuser  = out_flags;

endmodule

@@ rtl/rip_checker.sv @@
// Port-level checks for the radix integer text parser, bound to the top level.
// Depends on rip_pkg for the value range.
module rip_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Result request shown straight after reset.");

  a_nan_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 64'd0 && !m_axis_tuser[1]))
    else $error("Not-a-number result carries a value or a saturation flag.");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tdata == rip_pkg::VALUE_TOP - 64'd1 || m_axis_tdata == rip_pkg::VALUE_TOP ||
       m_axis_tdata == rip_pkg::VALUE_TOP + 64'd1))
    else $error("Saturated result is not at a range limit.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("Stalled result request changed.");

endmodule

bind radix_integer_text_parser rip_checker u_rip_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
